// ===== src/scsa_pkg.sv =====
// ---------------------------------------------------------------------------
// scsa_pkg: shared types and constants of the slab size class allocator
// Geometry of the page pool, item field widths, status codes, slot table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package scsa_pkg;

	// pool geometry
	localparam int NUM_PAGES      = 64;
	localparam int PAGE_BYTES     = 4096;
	localparam int DATA_BYTES     = 4032;
	localparam int NUM_CLASSES    = 64;
	localparam int MAX_SIZE       = 1024;
	localparam int ALIGN_BYTES    = 16;
	localparam int MAX_SLOTS      = DATA_BYTES / ALIGN_BYTES;
	localparam int WORDS_PER_PAGE = (MAX_SLOTS + 63) / 64;

	// derived widths
	localparam int PG_W    = $clog2(NUM_PAGES);
	localparam int OFF_W   = $clog2(PAGE_BYTES);
	localparam int WORD_W  = $clog2(WORDS_PER_PAGE);
	localparam int SLOT_W  = WORD_W + 6;
	localparam int CLS_W   = $clog2(NUM_CLASSES);
	localparam int ADDR_W  = 18;
	localparam int SIZE_W  = 12;
	localparam int NFP_W   = PG_W + 1;
	localparam int BM_AW   = PG_W + WORD_W;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_NO_PAGE  = 2'd2,
		ST_NO_MATCH = 2'd3
	} status_t;

	// one entry of the page table
	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic [SLOT_W-1:0] cnt;
		logic [SLOT_W-1:0] hint;
	} page_ent_t;

	localparam int PE_W = $bits(page_ent_t);

	// divider handshake
	typedef struct packed {
		logic             start;
		logic [7:0]       dividend;
		logic [CLS_W:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quot;
	} div_rsp_t;

	// result handed from the sequencer to the output register
	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [ADDR_W-1:0] addr;
	} res_t;

	// slots per page for each class: DATA_BYTES / (16 * (class + 1))
	localparam logic [SLOT_W-1:0] SLOTS_TBL [NUM_CLASSES] = '{
		8'd252, 8'd126, 8'd84, 8'd63, 8'd50, 8'd42, 8'd36, 8'd31,
		8'd28,  8'd25,  8'd22, 8'd21, 8'd19, 8'd18, 8'd16, 8'd15,
		8'd14,  8'd14,  8'd13, 8'd12, 8'd12, 8'd11, 8'd10, 8'd10,
		8'd10,  8'd9,   8'd9,  8'd9,  8'd8,  8'd8,  8'd8,  8'd7,
		8'd7,   8'd7,   8'd7,  8'd7,  8'd6,  8'd6,  8'd6,  8'd6,
		8'd6,   8'd6,   8'd5,  8'd5,  8'd5,  8'd5,  8'd5,  8'd5,
		8'd5,   8'd5,   8'd4,  8'd4,  8'd4,  8'd4,  8'd4,  8'd4,
		8'd4,   8'd4,   8'd4,  8'd4,  8'd4,  8'd4,  8'd4,  8'd3
	};

endpackage

// ===== src/scsa_req_if.sv =====
// ---------------------------------------------------------------------------
// scsa_req_if: request channel
// Valid/ready channel carrying one alloc or free request item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface scsa_req_if;
	import scsa_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [SIZE_W-1:0] size_bytes;
	logic [ADDR_W-1:0] free_address;

	modport source (output valid, kind, size_bytes, free_address, input ready);
	modport sink   (input valid, kind, size_bytes, free_address, output ready);
endinterface

// ===== src/scsa_rsp_if.sv =====
// ---------------------------------------------------------------------------
// scsa_rsp_if: response channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface scsa_rsp_if;
	import scsa_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ADDR_W-1:0] object_address;

	modport source (output valid, status, object_address, input ready);
	modport sink   (input valid, status, object_address, output ready);
endinterface

// ===== src/scsa_ram.sv =====
// ---------------------------------------------------------------------------
// scsa_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/scsa_div.sv =====
// ---------------------------------------------------------------------------
// scsa_div: iterative restoring divider
// Divides the 8-bit slot offset by the class multiple, one bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scsa_div (
	input  logic                clk,
	input  logic                arst_n,
	input  scsa_pkg::div_req_t  req,
	output scsa_pkg::div_rsp_t  rsp
);
	import scsa_pkg::*;

	logic [7:0]     q_q;
	logic [7:0]     r_q;
	logic [CLS_W:0] d_q;
	logic [3:0]     cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [7:0]     shifted;

	assign shifted = {r_q[6:0], q_q[7]};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 4'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd8;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: shift, compare, subtract
	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (busy_q) begin
			if (shifted >= 8'(d_q)) begin
				r_q <= shifted - 8'(d_q);
				q_q <= {q_q[6:0], 1'b1};
			end else begin
				r_q <= shifted;
				q_q <= {q_q[6:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = q_q;
endmodule

// ===== src/scsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// scsa_ctrl: request sequencer
// Walks page table and slot bitmaps in the two RAMs, read-modify-write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scsa_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_kind,
	input  logic [scsa_pkg::SIZE_W-1:0] in_size,
	input  logic [scsa_pkg::ADDR_W-1:0] in_faddr,
	input  logic                     out_free,
	output scsa_pkg::res_t           res,
	// page table RAM
	output logic                     pm_we,
	output logic [scsa_pkg::PG_W-1:0]  pm_waddr,
	output scsa_pkg::page_ent_t      pm_wdata,
	output logic [scsa_pkg::PG_W-1:0]  pm_raddr,
	input  scsa_pkg::page_ent_t      pm_rdata,
	// bitmap RAM
	output logic                     bm_we,
	output logic [scsa_pkg::BM_AW-1:0] bm_waddr,
	output logic [63:0]              bm_wdata,
	output logic [scsa_pkg::BM_AW-1:0] bm_raddr,
	input  logic [63:0]              bm_rdata,
	// divider
	output scsa_pkg::div_req_t       dreq,
	input  scsa_pkg::div_rsp_t       drsp
);
	import scsa_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_A_PRD = 12'b0000_0000_0010,
		S_A_PCK = 12'b0000_0000_0100,
		S_A_BRD = 12'b0000_0000_1000,
		S_A_BCK = 12'b0000_0001_0000,
		S_A_TAK = 12'b0000_0010_0000,
		S_A_GRW = 12'b0000_0100_0000,
		S_A_NEW = 12'b0000_1000_0000,
		S_F_DIV = 12'b0001_0000_0000,
		S_F_RD  = 12'b0010_0000_0000,
		S_F_CK  = 12'b0100_0000_0000,
		S_FIN   = 12'b1000_0000_0000
	} state_t;

	state_t             state_q;
	logic [NFP_W-1:0]   nfp_q;
	logic [CLS_W-1:0]   cls_q;
	logic [PG_W-1:0]    pg_q;
	logic [PG_W-1:0]    fpg_q;
	logic [WORD_W-1:0]  word_q;
	logic               pass_q;
	logic [SLOT_W-1:0]  h_q;
	logic [SLOT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0]  s_q;
	logic [63:0]        w_q;
	status_t            res_status_q;
	logic [ADDR_W-1:0]  res_addr_q;

	logic [SLOT_W-1:0]  slots;
	logic [SLOT_W-1:0]  hclamp;
	logic [63:0]        cand;
	logic [5:0]         first;
	logic               size_ok;
	logic [CLS_W-1:0]   in_cls;
	logic [SIZE_W-1:0]  size_m1;
	logic [14:0]        prod;
	logic [ADDR_W:0]    take_addr;
	logic               free_ok;
	logic [SLOT_W-1:0]  idx;

	assign slots   = SLOTS_TBL[cls_q];
	assign size_m1 = in_size - SIZE_W'(1);
	assign in_cls  = size_m1[CLS_W+3:4];
	assign size_ok = (in_size != '0) && (in_size <= SIZE_W'(MAX_SIZE));
	assign hclamp  = (pm_rdata.hint > slots) ? slots : pm_rdata.hint;

	// free candidates of the current bitmap word within the search window
	always_comb begin
		cand = '0;
		idx  = '0;
		for (int i = 0; i < 64; i++) begin
			idx = {word_q, 6'(i)};
			cand[i] = !bm_rdata[i] && (idx < slots) &&
				(pass_q ? (idx < h_q) : (idx >= h_q));
		end
	end

	// lowest candidate bit
	always_comb begin
		first = '0;
		for (int i = 63; i >= 0; i--) begin
			if (cand[i]) begin
				first = 6'(i);
			end
		end
	end

	// slot address of a taken slot
	assign prod      = s_q * 7'({1'b0, cls_q} + 7'd1);
	assign take_addr = (ADDR_W+1)'({pg_q, OFF_W'(0)}) + (ADDR_W+1)'({prod, 4'b0});

	assign free_ok = ({1'b0, fpg_q} < nfp_q) && (pm_rdata.cls == cls_q) &&
		(pm_rdata.cnt != '0) && (s_q < slots) && bm_rdata[s_q[5:0]];

	// RAM addresses
	assign pm_raddr = pg_q;
	assign bm_raddr = {pg_q, word_q};

	// RAM writes
	always_comb begin
		pm_we    = 1'b0;
		pm_waddr = pg_q;
		pm_wdata = '0;
		bm_we    = 1'b0;
		bm_waddr = {pg_q, word_q};
		bm_wdata = '0;
		unique case (state_q)
			S_A_TAK: begin
				pm_we    = 1'b1;
				pm_wdata = '{cls: cls_q, cnt: cnt_q + SLOT_W'(1), hint: s_q + SLOT_W'(1)};
				bm_we    = 1'b1;
				bm_waddr = {pg_q, s_q[SLOT_W-1:6]};
				bm_wdata = w_q | (64'd1 << s_q[5:0]);
			end
			S_A_NEW: begin
				pm_we    = (word_q == '0);
				pm_wdata = '{cls: cls_q, cnt: SLOT_W'(1), hint: SLOT_W'(1)};
				bm_we    = 1'b1;
				bm_wdata = (word_q == '0) ? 64'd1 : 64'd0;
			end
			S_F_CK: begin
				pm_we    = free_ok;
				pm_wdata = '{cls: cls_q, cnt: pm_rdata.cnt - SLOT_W'(1), hint: s_q};
				bm_we    = free_ok;
				bm_wdata = bm_rdata & ~(64'd1 << s_q[5:0]);
			end
			default: begin
			end
		endcase
	end

	// divider start on an accepted free with a good size and an offset inside the data area
	assign dreq.start    = in_valid && in_ready && in_kind && size_ok &&
		(in_faddr[OFF_W-1:0] < OFF_W'(DATA_BYTES));
	assign dreq.dividend = in_faddr[OFF_W-1:4];
	assign dreq.divisor  = {1'b0, in_cls} + (CLS_W+1)'(1);

	assign in_ready   = (state_q == S_IDLE);
	assign res.valid  = (state_q == S_FIN);
	assign res.status = res_status_q;
	assign res.addr   = res_addr_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nfp_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!size_ok) begin
							state_q <= S_FIN;
						end else if (in_kind) begin
							state_q <= dreq.start ? S_F_DIV : S_FIN;
						end else begin
							state_q <= (nfp_q == '0) ? S_A_GRW : S_A_PRD;
						end
					end
				end
				S_A_PRD: state_q <= S_A_PCK;
				S_A_PCK: begin
					if (pm_rdata.cls == cls_q && pm_rdata.cnt < slots) begin
						state_q <= S_A_BRD;
					end else begin
						state_q <= (pg_q == '0) ? S_A_GRW : S_A_PRD;
					end
				end
				S_A_BRD: state_q <= S_A_BCK;
				S_A_BCK: begin
					if (cand != '0) begin
						state_q <= S_A_TAK;
					end else if (word_q == WORD_W'(WORDS_PER_PAGE - 1) && pass_q) begin
						state_q <= (pg_q == '0) ? S_A_GRW : S_A_PRD;
					end else begin
						state_q <= S_A_BRD;
					end
				end
				S_A_TAK: state_q <= S_FIN;
				S_A_GRW: state_q <= nfp_q[PG_W] ? S_FIN : S_A_NEW;
				S_A_NEW: begin
					if (word_q == WORD_W'(WORDS_PER_PAGE - 1)) begin
						nfp_q   <= nfp_q + NFP_W'(1);
						state_q <= S_FIN;
					end
				end
				S_F_DIV: state_q <= drsp.done ? S_F_RD : S_F_DIV;
				S_F_RD:  state_q <= S_F_CK;
				S_F_CK:  state_q <= S_FIN;
				S_FIN:   state_q <= out_free ? S_IDLE : S_FIN;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cls_q        <= in_cls;
				fpg_q        <= in_faddr[ADDR_W-1:OFF_W];
				pg_q         <= PG_W'(nfp_q - NFP_W'(1));
				res_addr_q   <= '0;
				res_status_q <= !size_ok ? ST_BAD_SIZE : (in_kind ? ST_NO_MATCH : ST_OK);
			end
			S_A_PCK: begin
				cnt_q  <= pm_rdata.cnt;
				h_q    <= hclamp;
				pass_q <= 1'b0;
				word_q <= hclamp[SLOT_W-1:6];
				if (!(pm_rdata.cls == cls_q && pm_rdata.cnt < slots)) begin
					pg_q <= pg_q - PG_W'(1);
				end
			end
			S_A_BCK: begin
				if (cand != '0) begin
					s_q <= {word_q, first};
					w_q <= bm_rdata;
				end else if (word_q == WORD_W'(WORDS_PER_PAGE - 1)) begin
					pass_q <= 1'b1;
					word_q <= '0;
					if (pass_q) begin
						pg_q <= pg_q - PG_W'(1);
					end
				end else begin
					word_q <= word_q + WORD_W'(1);
				end
			end
			S_A_TAK: res_addr_q <= take_addr[ADDR_W-1:0];
			S_A_GRW: begin
				pg_q   <= nfp_q[PG_W-1:0];
				word_q <= '0;
				if (nfp_q[PG_W]) begin
					res_status_q <= ST_NO_PAGE;
				end
			end
			S_A_NEW: begin
				word_q <= word_q + WORD_W'(1);
				if (word_q == WORD_W'(WORDS_PER_PAGE - 1)) begin
					res_addr_q <= {pg_q, OFF_W'(0)};
				end
			end
			S_F_DIV: begin
				s_q    <= drsp.quot;
				pg_q   <= fpg_q;
				word_q <= drsp.quot[SLOT_W-1:6];
			end
			S_F_CK: res_status_q <= free_ok ? ST_OK : ST_NO_MATCH;
			default: begin
			end
		endcase
	end
endmodule

// ===== src/slab_size_class_allocator_top.sv =====
// ---------------------------------------------------------------------------
// slab_size_class_allocator_top: slab allocator with 64 size classes
// Allocates and frees fixed size slots from a pool of 64 pages of 4 KiB.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one alloc (kind 0) or free (kind 1) item; rsp returns exactly
//   one result item per request: status and, for a good alloc, the address.
//   One request is worked on at a time; req.ready is high only while idle.
//   The page table and the slot bitmaps sit in two RAMs with registered read
//   data; the sequencer reads, modifies and writes them back.
//   A free waits on the bit-serial divider; an alloc reads the page table
//   for each page examined and the bitmap words it searches, and writes all
//   4 bitmap words of a fresh page when it takes one.
//   Of the pool state, reset clears the page counter only; pages at or past
//   it count as unassigned, and a page's bitmap is written when it is taken,
//   so no clearing pass runs after reset.
//   A result waits in the output register while rsp.ready is low; a
//   finished request holds the sequencer until that register frees up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slab_size_class_allocator_top (
	input  logic      clk,
	input  logic      arst_n,
	scsa_req_if.sink  req,
	scsa_rsp_if.source rsp
);
	import scsa_pkg::*;

	res_t               res;
	logic               out_free;
	logic               pm_we;
	logic [PG_W-1:0]    pm_waddr;
	page_ent_t          pm_wdata;
	logic [PG_W-1:0]    pm_raddr;
	page_ent_t          pm_rdata;
	logic               bm_we;
	logic [BM_AW-1:0]   bm_waddr;
	logic [63:0]        bm_wdata;
	logic [BM_AW-1:0]   bm_raddr;
	logic [63:0]        bm_rdata;
	div_req_t           dreq;
	div_rsp_t           drsp;
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [ADDR_W-1:0]  out_addr_q;

	assign out_free = !out_valid_q || rsp.ready;

	scsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_kind  (req.kind),
		.in_size  (req.size_bytes),
		.in_faddr (req.free_address),
		.out_free (out_free),
		.res      (res),
		.pm_we    (pm_we),
		.pm_waddr (pm_waddr),
		.pm_wdata (pm_wdata),
		.pm_raddr (pm_raddr),
		.pm_rdata (pm_rdata),
		.bm_we    (bm_we),
		.bm_waddr (bm_waddr),
		.bm_wdata (bm_wdata),
		.bm_raddr (bm_raddr),
		.bm_rdata (bm_rdata),
		.dreq     (dreq),
		.drsp     (drsp)
	);

	scsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// page table: class, use count, search hint per page
	scsa_ram #(.WIDTH(PE_W), .DEPTH(NUM_PAGES)) u_page_ram (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wdata (pm_wdata),
		.raddr (pm_raddr),
		.rdata (pm_rdata)
	);

	// slot bitmaps, WORDS_PER_PAGE words per page
	scsa_ram #(.WIDTH(64), .DEPTH(NUM_PAGES * WORDS_PER_PAGE)) u_bitmap_ram (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && out_free) begin
			out_status_q <= res.status;
			out_addr_q   <= res.addr;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.object_address = out_addr_q;
endmodule

// ===== src/scsa_checker.sv =====
// ---------------------------------------------------------------------------
// scsa_checker: port level checks of the allocator
// Watches the request and response channels at the top level ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scsa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  out_status,
	input logic [scsa_pkg::ADDR_W-1:0] out_addr
);
	import scsa_pkg::*;

	// one request at a time: busy right after an accepted item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while a request is in work");

	// a stalled result holds its payload
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_addr))
		else $error("stalled result changed");

	// failed requests carry a zero address
	a_err_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_OK |-> out_addr == '0)
		else $error("error result with nonzero address");

	// slots never reach into the page tail
	a_addr_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_addr[OFF_W-1:0] < OFF_W'(DATA_BYTES))
		else $error("object address in page tail");
endmodule

bind slab_size_class_allocator_top scsa_checker u_scsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_status (rsp.status),
	.out_addr   (rsp.object_address)
);

// ===== tb/scsa_checker.sv =====
// ---------------------------------------------------------------------------
// scsa_scoreboard: result predictor and scoreboard for the slab allocator
// Watches both channels, predicts each result from its own page table and
// slot bitmaps, and compares every result item field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scsa_scoreboard
	import scsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	scsa_req_if  req,
	scsa_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] addr;
	} alloc_result_t;

	localparam logic [6:0] CLS_FREE = 7'd64;

	// shadow allocator state
	logic [6:0]  shadow_cls  [NUM_PAGES];
	logic [7:0]  shadow_cnt  [NUM_PAGES];
	logic [7:0]  shadow_hint [NUM_PAGES];
	logic [63:0] shadow_map  [NUM_PAGES][WORDS_PER_PAGE];
	logic [6:0]  shadow_next;

	alloc_result_t expected_q[$];
	int            mismatches;

	assign pending    = expected_q.size();
	assign fail_count = mismatches;

	function automatic logic slot_busy(int pg, int s);
		return shadow_map[pg][s / 64][s % 64];
	endfunction

	function automatic void grab_slot(int pg, int s);
		shadow_map[pg][s / 64][s % 64] = 1'b1;
		shadow_hint[pg] = 8'(s + 1);
		shadow_cnt[pg]  = shadow_cnt[pg] + 8'd1;
	endfunction

	// apply one request to the shadow state, return its result
	function automatic alloc_result_t apply_request(logic kind, logic [SIZE_W-1:0] size,
			logic [ADDR_W-1:0] faddr);
		alloc_result_t r;
		int rounded, cls, slots, h, s, found, pg, off;
		r.status = ST_OK;
		r.addr   = '0;
		if (size == 0 || size > MAX_SIZE) begin
			r.status = ST_BAD_SIZE;
			return r;
		end
		rounded = (int'(size) + 15) & ~15;
		cls     = rounded / 16 - 1;
		if (cls >= NUM_CLASSES) begin
			r.status = ST_BAD_SIZE;
			return r;
		end
		slots = DATA_BYTES / rounded;
		if (kind == 1'b0) begin
			// newest page of the class first, search from hint and wrap
			for (pg = NUM_PAGES - 1; pg >= 0; pg--) begin
				if (shadow_cls[pg] != 7'(cls) || shadow_cnt[pg] >= slots)
					continue;
				h = shadow_hint[pg];
				if (h > slots)
					h = slots;
				found = -1;
				for (s = h; s < slots && found < 0; s++)
					if (!slot_busy(pg, s))
						found = s;
				for (s = 0; s < h && found < 0; s++)
					if (!slot_busy(pg, s))
						found = s;
				if (found >= 0) begin
					grab_slot(pg, found);
					r.addr = ADDR_W'(pg * PAGE_BYTES + found * rounded);
					return r;
				end
			end
			if (shadow_next >= NUM_PAGES) begin
				r.status = ST_NO_PAGE;
				return r;
			end
			pg = shadow_next;
			shadow_next = shadow_next + 7'd1;
			shadow_cls[pg]  = 7'(cls);
			shadow_cnt[pg]  = '0;
			shadow_hint[pg] = '0;
			for (int w = 0; w < WORDS_PER_PAGE; w++)
				shadow_map[pg][w] = '0;
			grab_slot(pg, 0);
			r.addr = ADDR_W'(pg * PAGE_BYTES);
			return r;
		end
		// free
		pg  = int'(faddr) / PAGE_BYTES;
		off = int'(faddr) % PAGE_BYTES;
		if (pg >= NUM_PAGES || off >= DATA_BYTES) begin
			r.status = ST_NO_MATCH;
			return r;
		end
		s = off / rounded;
		if (shadow_cls[pg] != 7'(cls) || shadow_cnt[pg] == 0 || s >= slots
				|| !slot_busy(pg, s)) begin
			r.status = ST_NO_MATCH;
			return r;
		end
		shadow_map[pg][s / 64][s % 64] = 1'b0;
		shadow_cnt[pg]  = shadow_cnt[pg] - 8'd1;
		shadow_hint[pg] = 8'(s);
		return r;
	endfunction

	// compare results first, then record new requests
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			for (int p = 0; p < NUM_PAGES; p++) begin
				shadow_cls[p]  = CLS_FREE;
				shadow_cnt[p]  = '0;
				shadow_hint[p] = '0;
				for (int w = 0; w < WORDS_PER_PAGE; w++)
					shadow_map[p][w] = '0;
			end
			shadow_next = '0;
			expected_q.delete();
			mismatches = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result status %0d addr %0h", $realtime,
							rsp.status, rsp.object_address);
				end else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status || rsp.object_address !== want.addr) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp status %0d addr %0h, got %0d %0h",
								$realtime, want.status, want.addr, rsp.status,
								rsp.object_address);
					end
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(apply_request(req.kind, req.size_bytes,
					req.free_address));
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: testbench of the slab size class allocator
// Directed corner requests, then random alloc/free traffic mostly freeing
// live objects; random gaps on both channels; scoreboard does the comparing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import scsa_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 830;

	typedef struct {
		logic              kind;
		logic [SIZE_W-1:0] size;
	} sent_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} live_obj_t;

	logic clk;
	logic arst_n;
	logic no_idle;
	int   fail_count;
	int   pending;
	int   quiet_cycles;

	sent_t     sent_q[$];
	live_obj_t live_objs[$];

	scsa_req_if req ();
	scsa_rsp_if rsp ();

	slab_size_class_allocator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	scsa_scoreboard u_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk)
		rsp.ready <= no_idle || ($urandom_range(0, 99) >= 32);

	// track live allocations from the results
	always @(posedge clk) begin
		sent_t sent;
		if (arst_n) begin
			if (rsp.valid && rsp.ready && sent_q.size() > 0) begin
				sent = sent_q.pop_front();
				if (sent.kind == 1'b0 && rsp.status == ST_OK)
					live_objs.push_back('{rsp.object_address, sent.size});
			end
			if (req.valid && req.ready)
				sent_q.push_back('{req.kind, req.size_bytes});
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[slab_size_class_allocator_top] ERROR");
			$finish;
		end
	end

	task automatic send_item(logic kind, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] faddr);
		while (!no_idle && $urandom_range(0, 99) < 32) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid        <= 1'b1;
		req.kind         <= kind;
		req.size_bytes   <= size;
		req.free_address <= faddr;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// one random request: mostly allocs of a few classes and frees of live objects
	task automatic random_item();
		int pick, idx, cls, rounded;
		live_obj_t obj;
		logic [ADDR_W-1:0] addr;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			case ($urandom_range(0, 9))
				0: cls = 0;
				1: cls = 1;
				2: cls = 3;
				3: cls = 7;
				4: cls = 15;
				5: cls = 31;
				6: cls = 63;
				7: cls = $urandom_range(0, 4);
				default: cls = $urandom_range(0, 63);
			endcase
			send_item(1'b0, SIZE_W'(cls * 16 + $urandom_range(1, 16)), ADDR_W'($urandom));
		end else if (pick < 82 && live_objs.size() > 0) begin
			idx = $urandom_range(0, live_objs.size() - 1);
			obj = live_objs[idx];
			live_objs.delete(idx);
			rounded = (int'(obj.size) + 15) & ~15;
			addr = obj.addr;
			if ($urandom_range(0, 3) == 0)
				addr = addr + ADDR_W'($urandom_range(0, rounded - 1));
			send_item(1'b1, obj.size, addr);
		end else begin
			send_item(1'($urandom), SIZE_W'($urandom), ADDR_W'($urandom));
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		no_idle          = 1'b0;
		quiet_cycles     = 0;
		req.valid        = 1'b0;
		req.kind         = 1'b0;
		req.size_bytes   = '0;
		req.free_address = '0;
		rsp.ready        = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_item(1'b0, 12'd0, '0);              // zero size alloc
		send_item(1'b1, 12'd0, '0);              // zero size free
		send_item(1'b0, 12'd1025, '0);           // just above max
		send_item(1'b0, 12'd4095, '1);           // largest field value
		send_item(1'b1, 12'd2000, 18'd16);       // oversized free
		send_item(1'b0, 12'd16, '0);             // fresh page 0
		send_item(1'b0, 12'd1, '0);              // next slot
		send_item(1'b1, 12'd16, 18'd0);          // good free
		send_item(1'b1, 12'd16, 18'd0);          // slot already clear
		send_item(1'b1, 12'd9, 18'd21);          // unaligned free
		send_item(1'b1, 12'd16, 18'd16);         // page count zero
		send_item(1'b0, 12'd1024, '0);           // largest class, page 1
		send_item(1'b1, 12'd1024, 18'd7168);     // slot index past slot count
		send_item(1'b1, 12'd1024, 18'd8128);     // page tail
		send_item(1'b1, 12'd16, 18'd4096);       // wrong class
		send_item(1'b1, 12'd1024, 18'h3FFFF);    // tail of unassigned last page
		send_item(1'b1, 12'd1024, 18'd4096);     // good free
		send_item(1'b0, 12'd1000, '0);           // another class
		send_item(1'b0, 12'd1024, '0);           // reuse page 1 from hint
		wait_drained();

		// random traffic, with a stretch free of idling
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_idle <= (n >= 300 && n < 450);
			if (n == 600)
				wait_drained();
			random_item();
		end
		req.valid <= 1'b0;
		no_idle   <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("[slab_size_class_allocator_top] OK");
		else
			$display("[slab_size_class_allocator_top] ERROR");
		$finish;
	end

endmodule
